// ===== src/geue_pkg.sv =====
`timescale 1ns / 1ps

package geue_pkg;

  localparam int NODE_W = 5;

  // input operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result change codes
  localparam logic [1:0] CODE_PRESENT = 2'd0;
  localparam logic [1:0] CODE_ADDED   = 2'd1;
  localparam logic [1:0] CODE_REMOVED = 2'd2;

  typedef enum logic {
    CMD_INSERT,
    CMD_DELETE
  } cmd_kind_t;

  // node_a: insert source or deleted node, node_b: insert target
  typedef struct packed {
    cmd_kind_t         kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } cmd_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [NODE_W-1:0] lowest_set(input logic [31:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        r = NODE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/graph_edge_update_engine.sv =====
`timescale 1ns / 1ps

// directed graph of NODES nodes held as an adjacency bit matrix
// input channel: in_valid/in_stall, one operation per transfer
//   in_op low inserts in_source_node -> in_target_node
//   in_op high deletes every edge touching in_removed_node
// result channel: out_valid/out_stall, one reported edge per transfer
//   insert gives one result, change code 0 (already there) or 1 (added)
//   delete gives one code 2 result per removed edge, outgoing edges in
//   ascending target order first, then incoming in ascending source order;
//   out_last_result marks the final result of the operation
// items naming a node of NODES or more, and deletes with no edges, give
// no result
// with an empty queue an insert result passes the queue entry and then the
// result register; a delete result passes the queue entry, the row and column
// mask registers and then the result register; a delete with E removed edges
// (at most 2*NODES-1) keeps the back end in S_SCAN while the scan of the row
// and column masks gives a single result per cycle, unless out_stall holds it
// a two-entry command queue lets inputs be taken while the scan runs
// reset clears the whole matrix at once; no clearing pass is needed
// when out_stall is high the result register holds and the scan pauses;
// once the queue is full in_stall rises

module graph_edge_update_engine
  import geue_pkg::*;
#(
  parameter int NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_target_node,
  input  logic [NODE_W-1:0] in_removed_node,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_edge_source,
  output logic [NODE_W-1:0] out_edge_target,
  output logic [1:0]        out_change_code,
  output logic              out_last_result
);

  localparam logic [NODE_W:0] NODE_LIM = (NODE_W + 1)'(NODES);

  // command queue between classify and execute
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // front end: range check, classify, queue
  geue_front #(
    .NODES(NODES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_source_node (in_source_node),
    .in_target_node (in_target_node),
    .in_removed_node(in_removed_node),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  // back end: matrix, delete scan and result register
  geue_back #(
    .NODES(NODES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_source(out_edge_source),
    .out_edge_target(out_edge_target),
    .out_change_code(out_change_code),
    .out_last_result(out_last_result)
  );

  // the back end never pops an empty queue
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // only in-range commands reach the back end
  a_cmd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ({1'b0, q_cmd.node_a} < NODE_LIM))
    else $error("out-of-range node in command queue");

  // insert results are always the final result of their item
  a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_change_code != CODE_REMOVED)) |-> out_last_result)
    else $error("insert result without last mark");

  // the result code never takes the unused value
  a_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_code == CODE_PRESENT ||
                   out_change_code == CODE_ADDED ||
                   out_change_code == CODE_REMOVED))
    else $error("invalid change code");

endmodule

// ===== src/geue_front.sv =====
`timescale 1ns / 1ps

module geue_front
  import geue_pkg::*;
#(
  parameter int NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_target_node,
  input  logic [NODE_W-1:0] in_removed_node,
  output logic              q_valid,
  output cmd_t              q_cmd,
  input  logic              q_pop
);

  localparam logic [NODE_W:0] NODE_LIM = (NODE_W + 1)'(NODES);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  cmd_t cmd;
  logic in_range;
  logic push;

  // classify: build the command and drop items naming nodes out of range
  always_comb begin
    cmd = '0;
    if (in_op == OP_INSERT) begin
      cmd.kind   = CMD_INSERT;
      cmd.node_a = in_source_node;
      cmd.node_b = in_target_node;
      in_range   = ({1'b0, in_source_node} < NODE_LIM) &&
                   ({1'b0, in_target_node} < NODE_LIM);
    end else begin
      cmd.kind   = CMD_DELETE;
      cmd.node_a = in_removed_node;
      in_range   = ({1'b0, in_removed_node} < NODE_LIM);
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && in_range;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== src/geue_back.sv =====
`timescale 1ns / 1ps

module geue_back
  import geue_pkg::*;
#(
  parameter int NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_edge_source,
  output logic [NODE_W-1:0] out_edge_target,
  output logic [1:0]        out_change_code,
  output logic              out_last_result
);

  localparam int IDX_W = $clog2(NODES);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r;

  logic [NODES-1:0]  adj_r [NODES];
  logic [NODES-1:0]  row_mask_r, col_mask_r;
  logic [NODE_W-1:0] node_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_src_r, out_dst_r;
  logic [1:0]        out_code_r;
  logic              out_last_r;

  logic              out_free;
  logic [IDX_W-1:0]  a_idx, b_idx;
  logic [NODES-1:0]  col, nbit, row_rest, col_rest;
  logic              present;
  logic              do_insert, do_delete;
  logic [NODE_W-1:0] row_hit, col_hit;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign a_idx    = q_cmd.node_a[IDX_W-1:0];
  assign b_idx    = q_cmd.node_b[IDX_W-1:0];
  assign present  = adj_r[a_idx][b_idx];
  assign nbit     = NODES'(1) << a_idx;

  assign do_insert = q_pop && (q_cmd.kind == CMD_INSERT);
  assign do_delete = q_pop && (q_cmd.kind == CMD_DELETE);

  // column of the deleted node, one fixed bit of every row
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      col[i] = adj_r[i][a_idx];
    end
  end

  // drop the lowest pending edge of each mask
  assign row_rest = row_mask_r & (row_mask_r - NODES'(1));
  assign col_rest = col_mask_r & (col_mask_r - NODES'(1));
  assign row_hit  = lowest_set(32'(row_mask_r));
  assign col_hit  = lowest_set(32'(col_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        adj_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NODES; i++) begin
        if (do_insert && (IDX_W'(i) == a_idx)) begin
          adj_r[i][b_idx] <= 1'b1;
        end
        if (do_delete) begin
          if (IDX_W'(i) == a_idx) begin
            adj_r[i] <= '0;
          end else begin
            adj_r[i][a_idx] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_free) begin
            out_valid_r <= do_insert;
          end
          if (do_insert) begin
            out_src_r  <= q_cmd.node_a;
            out_dst_r  <= q_cmd.node_b;
            out_code_r <= present ? CODE_PRESENT : CODE_ADDED;
            out_last_r <= 1'b1;
          end
          if (do_delete) begin
            // self loop stays in the row mask only
            row_mask_r <= adj_r[a_idx];
            col_mask_r <= col & ~nbit;
            node_r     <= q_cmd.node_a;
            if ((adj_r[a_idx] != '0) || ((col & ~nbit) != '0)) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= CODE_REMOVED;
            if (row_mask_r != '0) begin
              out_src_r  <= node_r;
              out_dst_r  <= row_hit;
              out_last_r <= (row_rest == '0) && (col_mask_r == '0);
              row_mask_r <= row_rest;
              if ((row_rest == '0) && (col_mask_r == '0)) begin
                state_r <= S_IDLE;
              end
            end else begin
              out_src_r  <= col_hit;
              out_dst_r  <= node_r;
              out_last_r <= (col_rest == '0);
              col_mask_r <= col_rest;
              if (col_rest == '0) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_source = out_src_r;
  assign out_edge_target = out_dst_r;
  assign out_change_code = out_code_r;
  assign out_last_result = out_last_r;

endmodule
